// ===== sv/ps2_hse_pkg.sv =====
// Shared types and codes for the PS/2 host serial engine.
// Request and result payload structs, action codes and error codes.
// No dependencies.
package ps2_hse_pkg;

    typedef enum logic [1:0] {
        ACT_EDGE   = 2'd0,
        ACT_SEND   = 2'd1,
        ACT_POP    = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_START     = 3'd1,
        ERR_PARITY    = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_STOP      = 3'd4,
        ERR_ACK       = 3'd5
    } error_t;

    typedef struct packed {
        action_t    action;
        logic       data_bit;
        logic [7:0] send_byte;
    } cmd_t;

    typedef struct packed {
        logic       data_drive_enable;
        logic       data_drive_level;
        logic       start_request;
        logic [7:0] popped_byte;
        logic       popped_valid;
        logic [3:0] bytes_available;
        logic       frame_received;
        logic       send_done;
        logic       sending_busy;
        error_t     error_code;
    } res_t;

    localparam logic [3:0] AVAIL_MAX = 4'd15;

endpackage

// ===== sv/ps2_host_serial_engine.sv =====
// PS/2 host serial engine: frame receive/transmit sequencer and receive ring FIFO.
// Depends on ps2_hse_pkg for the payload structs and the action and error codes.
//
//   channel  | valid      | stall      | payload
//   ---------+------------+------------+------------------------------
//   request  | cmd_valid  | cmd_stall  | cmd (action, data_bit, send_byte)
//   result   | res_valid  | res_stall  | res (line drive, FIFO and status)
//
// Every request is accepted while cmd_stall is low and yields one result:
// the state update and FIFO read are registered in a first stage, then the
// result sits in the output register. One request per cycle while res_stall is low.
// A stalled result holds in the output register while the first stage still
// takes one more request; cmd_stall rises only when both stages are full.
// Reset clears the sequencer, indices and line drive; FIFO contents need none.
module ps2_host_serial_engine #(
    parameter int FIFO_SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  ps2_hse_pkg::cmd_t cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output ps2_hse_pkg::res_t res
);
    import ps2_hse_pkg::*;

    localparam int IDX_W = $clog2(FIFO_SLOTS);
    localparam int CNT_W = (IDX_W + 1 > 4) ? IDX_W + 1 : 4;
    localparam logic [IDX_W:0]   SLOTS_W  = (IDX_W + 1)'(FIFO_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_SLOTS - 1);

    // Frame sequencer phases; data phases count bits with bit_cnt.
    typedef enum logic [7:0] {
        PH_R_START  = 8'b0000_0001,
        PH_R_DATA   = 8'b0000_0010,
        PH_R_PARITY = 8'b0000_0100,
        PH_R_STOP   = 8'b0000_1000,
        PH_S_DATA   = 8'b0001_0000,
        PH_S_PARITY = 8'b0010_0000,
        PH_S_STOP   = 8'b0100_0000,
        PH_S_ACK    = 8'b1000_0000
    } phase_t;

    phase_t           phase_reg,  phase_next;
    logic [2:0]       bit_cnt_reg, bit_cnt_next;
    logic [7:0]       shift_reg,  shift_next;
    logic             parity_reg, parity_next;
    logic             drive_reg,  drive_next;
    logic             level_reg,  level_next;
    logic [IDX_W-1:0] widx_reg,   widx_next;
    logic [IDX_W-1:0] ridx_reg,   ridx_next;

    logic [7:0]       fifo_mem [FIFO_SLOTS];
    logic             wr_en;
    logic             rd_en;
    logic [7:0]       rdata_reg;

    logic             s1_valid_reg, s1_valid_next;
    res_t             s1_reg,       s1_next;
    res_t             s1_out;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg;

    logic             accept;
    logic             s1_adv;
    logic [IDX_W-1:0] widx_inc;
    logic [IDX_W-1:0] ridx_inc;
    logic [IDX_W:0]   diff_wide;
    logic [CNT_W-1:0] fill_cnt;

    // Handshake: stage one moves on when the output register is free or drains.
    assign s1_adv    = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = s1_valid_reg && !s1_adv;
    assign accept    = cmd_valid && !cmd_stall;

    assign widx_inc = (widx_reg == LAST_IDX) ? '0 : widx_reg + 1'b1;
    assign ridx_inc = (ridx_reg == LAST_IDX) ? '0 : ridx_reg + 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        parity_next  = parity_reg;
        drive_next   = drive_reg;
        level_next   = level_reg;
        widx_next    = widx_reg;
        ridx_next    = ridx_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        s1_next      = '0;
        s1_next.error_code = ERR_NONE;

        if (accept)
        begin
            case (cmd.action)
                ACT_SEND:
                begin
                    // Load the byte and pull the line low for the start bit.
                    phase_next    = PH_S_DATA;
                    bit_cnt_next  = '0;
                    shift_next    = cmd.send_byte;
                    parity_next   = 1'b1;
                    drive_next    = 1'b1;
                    level_next    = 1'b0;
                    s1_next.start_request = 1'b1;
                end
                ACT_POP:
                begin
                    // Leave the indices alone on an empty FIFO.
                    if (widx_reg != ridx_reg)
                    begin
                        rd_en     = 1'b1;
                        ridx_next = ridx_inc;
                        s1_next.popped_valid = 1'b1;
                    end
                end
                ACT_EDGE:
                begin
                    case (phase_reg)
                        PH_R_START:
                        begin
                            if (!cmd.data_bit)
                            begin
                                phase_next   = PH_R_DATA;
                                bit_cnt_next = '0;
                                shift_next   = '0;
                                parity_next  = 1'b1;
                            end
                            else
                            begin
                                s1_next.error_code = ERR_START;
                            end
                        end
                        PH_R_DATA:
                        begin
                            shift_next   = {cmd.data_bit, shift_reg[7:1]};
                            parity_next  = parity_reg ^ cmd.data_bit;
                            bit_cnt_next = bit_cnt_reg + 1'b1;
                            if (bit_cnt_reg == 3'd7)
                            begin
                                phase_next = PH_R_PARITY;
                            end
                        end
                        PH_R_PARITY:
                        begin
                            if (cmd.data_bit != parity_reg)
                            begin
                                s1_next.error_code = ERR_PARITY;
                                phase_next = PH_R_START;
                            end
                            else
                            begin
                                phase_next = PH_R_STOP;
                            end
                        end
                        PH_R_STOP:
                        begin
                            if (cmd.data_bit)
                            begin
                                if (widx_inc != ridx_reg)
                                begin
                                    wr_en     = 1'b1;
                                    widx_next = widx_inc;
                                    s1_next.frame_received = 1'b1;
                                end
                                else
                                begin
                                    s1_next.error_code = ERR_OVERFLOW;
                                end
                            end
                            else
                            begin
                                s1_next.error_code = ERR_STOP;
                            end
                            phase_next = PH_R_START;
                        end
                        PH_S_DATA:
                        begin
                            shift_next   = {1'b0, shift_reg[7:1]};
                            parity_next  = parity_reg ^ shift_reg[0];
                            drive_next   = 1'b1;
                            level_next   = shift_reg[0];
                            bit_cnt_next = bit_cnt_reg + 1'b1;
                            if (bit_cnt_reg == 3'd7)
                            begin
                                phase_next = PH_S_PARITY;
                            end
                        end
                        PH_S_PARITY:
                        begin
                            drive_next = 1'b1;
                            level_next = parity_reg;
                            phase_next = PH_S_STOP;
                        end
                        PH_S_STOP:
                        begin
                            // Release the line so the device can drive ACK.
                            drive_next = 1'b0;
                            level_next = 1'b1;
                            phase_next = PH_S_ACK;
                        end
                        PH_S_ACK:
                        begin
                            if (cmd.data_bit)
                            begin
                                s1_next.error_code = ERR_ACK;
                            end
                            else
                            begin
                                s1_next.send_done = 1'b1;
                            end
                            phase_next = PH_R_START;
                        end
                        default:
                        begin
                            phase_next = PH_R_START;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        s1_next.data_drive_enable = drive_next;
        s1_next.data_drive_level  = level_next;
        s1_next.bytes_available   = (fill_cnt > CNT_W'(AVAIL_MAX)) ? AVAIL_MAX
                                                                     : fill_cnt[3:0];
        s1_next.sending_busy = (phase_next == PH_S_DATA) || (phase_next == PH_S_PARITY) ||
                               (phase_next == PH_S_STOP) || (phase_next == PH_S_ACK);
    end

    // Fill level after this request, from the updated ring indices.
    always_comb
    begin
        if (widx_next >= ridx_next)
        begin
            diff_wide = {1'b0, widx_next} - {1'b0, ridx_next};
        end
        else
        begin
            diff_wide = {1'b0, widx_next} + SLOTS_W - {1'b0, ridx_next};
        end
        fill_cnt = CNT_W'(diff_wide);
    end

    assign s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign res_valid_next = s1_adv ? 1'b1 : (res_stall ? res_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_R_START;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            parity_reg    <= 1'b1;
            drive_reg     <= 1'b0;
            level_reg     <= 1'b1;
            widx_reg      <= '0;
            ridx_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            parity_reg    <= parity_next;
            drive_reg     <= drive_next;
            level_reg     <= level_next;
            widx_reg      <= widx_next;
            ridx_reg      <= ridx_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Receive FIFO storage with registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fifo_mem[widx_reg] <= shift_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= fifo_mem[ridx_reg];
        end
    end

    // Merge the FIFO read data into the stage-one result; zero it on an empty pop.
    always_comb
    begin
        s1_out             = s1_reg;
        s1_out.popped_byte = s1_reg.popped_valid ? rdata_reg : 8'd0;
    end

    // Payload registers: load stage one on accept, output on advance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            res_reg <= s1_out;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/ps2_hse_checker.sv =====
// Port-level checks for the PS/2 host serial engine, bound to the top level.
// Depends on ps2_hse_pkg and on ps2_host_serial_engine for the bind.
module ps2_hse_sva (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  ps2_hse_pkg::cmd_t cmd,
    input  logic              res_valid,
    input  logic              res_stall,
    input  ps2_hse_pkg::res_t res
);
    import ps2_hse_pkg::*;

    // Hold a stalled result.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // Drop the popped byte to zero when the pop found nothing.
    a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.popped_valid |-> res.popped_byte == 8'd0)
        else $error("popped byte nonzero without a byte");

    // A send request drives the start bit and marks the transfer busy.
    a_send_start: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.start_request |->
            res.sending_busy && res.data_drive_enable && !res.data_drive_level)
        else $error("send request without start bit");

    // An acknowledged send ends the transfer with the line released.
    a_send_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.send_done |->
            !res.sending_busy && !res.data_drive_enable && res.error_code == ERR_NONE)
        else $error("send done with transfer still active");

    // A stored frame leaves at least one byte and no error.
    a_frame_fill: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.frame_received |->
            res.bytes_available != 4'd0 && res.error_code == ERR_NONE)
        else $error("frame received with empty FIFO or error");

endmodule

bind ps2_host_serial_engine ps2_hse_sva u_ps2_hse_sva (.*);

// ===== dv/ps2_hse_checker.sv =====
// Checker for the PS/2 host serial engine: watches both channels, predicts each result.
// Depends on ps2_hse_pkg for the request and result structs and the codes.
`timescale 1ns / 1ps

module ps2_hse_checker #(
    parameter int FIFO_SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  ps2_hse_pkg::cmd_t cmd,
    input  logic              res_valid,
    input  logic              res_stall,
    input  ps2_hse_pkg::res_t res,
    output int                fail_count,
    output int                pending
);
    import ps2_hse_pkg::*;

    localparam logic [4:0] RX_START  = 5'd0;
    localparam logic [4:0] RX_DATA0  = 5'd1;
    localparam logic [4:0] RX_PARITY = 5'd9;
    localparam logic [4:0] RX_STOP   = 5'd10;
    localparam logic [4:0] TX_DATA0  = 5'd11;
    localparam logic [4:0] TX_PARITY = 5'd19;
    localparam logic [4:0] TX_STOP   = 5'd20;
    localparam logic [4:0] TX_ACK    = 5'd21;

    logic [4:0]  seq_phase;
    logic [7:0]  shreg;
    logic        par_acc;
    logic [7:0]  rx_mem [FIFO_SLOTS];
    int unsigned wr_idx;
    int unsigned rd_idx;
    logic        drv_en;
    logic        drv_lvl;

    res_t expected_q [$];
    res_t oldest;
    int   diffs;

    // Advance the engine model by one request and return the result it causes.
    function automatic res_t model_request(cmd_t c);
        res_t        r;
        int unsigned nxt;
        int unsigned cnt;
        r = '0;
        r.error_code = ERR_NONE;
        case (c.action)
            ACT_SEND: begin
                seq_phase = TX_DATA0;
                shreg = c.send_byte;
                par_acc = 1'b1;
                drv_en = 1'b1;
                drv_lvl = 1'b0;
                r.start_request = 1'b1;
            end
            ACT_POP: begin
                if (wr_idx != rd_idx) begin
                    r.popped_byte = rx_mem[rd_idx];
                    r.popped_valid = 1'b1;
                    rd_idx = (rd_idx + 1) % FIFO_SLOTS;
                end
            end
            ACT_EDGE: begin
                if (seq_phase == RX_START) begin
                    if (!c.data_bit) begin
                        seq_phase = RX_DATA0;
                        shreg = 8'h00;
                        par_acc = 1'b1;
                    end else begin
                        r.error_code = ERR_START;
                    end
                end else if (seq_phase >= RX_DATA0 && seq_phase < RX_PARITY) begin
                    shreg = {c.data_bit, shreg[7:1]};
                    if (c.data_bit)
                        par_acc = ~par_acc;
                    seq_phase = seq_phase + 5'd1;
                end else if (seq_phase == RX_PARITY) begin
                    if (c.data_bit != par_acc) begin
                        r.error_code = ERR_PARITY;
                        seq_phase = RX_START;
                    end else begin
                        seq_phase = RX_STOP;
                    end
                end else if (seq_phase == RX_STOP) begin
                    nxt = (wr_idx + 1) % FIFO_SLOTS;
                    if (!c.data_bit) begin
                        r.error_code = ERR_STOP;
                    end else if (nxt == rd_idx) begin
                        r.error_code = ERR_OVERFLOW;
                    end else begin
                        rx_mem[wr_idx] = shreg;
                        wr_idx = nxt;
                        r.frame_received = 1'b1;
                    end
                    seq_phase = RX_START;
                end else if (seq_phase >= TX_DATA0 && seq_phase < TX_PARITY) begin
                    if (shreg[0])
                        par_acc = ~par_acc;
                    drv_en = 1'b1;
                    drv_lvl = shreg[0];
                    shreg = shreg >> 1;
                    seq_phase = seq_phase + 5'd1;
                end else if (seq_phase == TX_PARITY) begin
                    drv_en = 1'b1;
                    drv_lvl = par_acc;
                    seq_phase = TX_STOP;
                end else if (seq_phase == TX_STOP) begin
                    drv_en = 1'b0;
                    drv_lvl = 1'b1;
                    seq_phase = TX_ACK;
                end else if (seq_phase == TX_ACK) begin
                    if (c.data_bit)
                        r.error_code = ERR_ACK;
                    else
                        r.send_done = 1'b1;
                    seq_phase = RX_START;
                end else begin
                    seq_phase = RX_START;
                end
            end
            default: ;
        endcase
        cnt = (wr_idx + FIFO_SLOTS - rd_idx) % FIFO_SLOTS;
        r.bytes_available = (cnt > AVAIL_MAX) ? AVAIL_MAX : 4'(cnt);
        r.data_drive_enable = drv_en;
        r.data_drive_level = drv_lvl;
        r.sending_busy = (seq_phase >= TX_DATA0 && seq_phase <= TX_ACK);
        return r;
    endfunction

    function automatic int field_diff(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            seq_phase = RX_START;
            shreg = 8'h00;
            par_acc = 1'b1;
            wr_idx = 0;
            rd_idx = 0;
            drv_en = 1'b0;
            drv_lvl = 1'b1;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cmd_valid && !cmd_stall)
                expected_q.push_back(model_request(cmd));
            if (res_valid && !res_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end else begin
                    oldest = expected_q.pop_front();
                    diffs = 0;
                    diffs += field_diff("data_drive_enable",
                                        8'(oldest.data_drive_enable), 8'(res.data_drive_enable));
                    diffs += field_diff("data_drive_level",
                                        8'(oldest.data_drive_level), 8'(res.data_drive_level));
                    diffs += field_diff("start_request",
                                        8'(oldest.start_request), 8'(res.start_request));
                    diffs += field_diff("popped_byte", oldest.popped_byte, res.popped_byte);
                    diffs += field_diff("popped_valid",
                                        8'(oldest.popped_valid), 8'(res.popped_valid));
                    diffs += field_diff("bytes_available",
                                        8'(oldest.bytes_available), 8'(res.bytes_available));
                    diffs += field_diff("frame_received",
                                        8'(oldest.frame_received), 8'(res.frame_received));
                    diffs += field_diff("send_done", 8'(oldest.send_done), 8'(res.send_done));
                    diffs += field_diff("sending_busy",
                                        8'(oldest.sending_busy), 8'(res.sending_busy));
                    diffs += field_diff("error_code",
                                        8'(oldest.error_code), 8'(res.error_code));
                    fail_count += diffs;
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== dv/ps2_host_serial_engine_tb.sv =====
// Top of the PS/2 host serial engine testbench: clock, reset, request stimulus, verdict.
// Depends on ps2_hse_pkg, ps2_host_serial_engine and ps2_hse_checker.
`timescale 1ns / 1ps

module ps2_host_serial_engine_tb;
    import ps2_hse_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 750;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 12;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    cmd_t cmd       = '0;
    logic res_stall = 1'b0;
    logic cmd_stall;
    logic res_valid;
    res_t res;

    int fail_count;
    int pending;

    // Idling control: idle_allowed drops for the tail of the run; within the run every
    // fourth window of 64 requests goes without any gaps or stalls.
    int   n_items    = 0;
    int   stall_left = 0;
    int   cycle_cnt  = 0;
    bit   idle_allowed = 1'b1;
    logic idle_on;

    assign idle_on = idle_allowed && ((n_items / 64) % 4 != 3);

    always #2 clk = ~clk;

    ps2_host_serial_engine #(
        .FIFO_SLOTS(SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    ps2_hse_checker #(
        .FIFO_SLOTS(SLOTS)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side backpressure: raise stall at random while idle_on, then hold it for a random burst.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_stall  <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            res_stall  <= 1'b1;
        end else begin
            res_stall  <= 1'b0;
        end
    end

    function automatic cmd_t make_cmd(action_t act, logic bit_v, logic [7:0] byte_v);
        cmd_t c;
        c.action    = act;
        c.data_bit  = bit_v;
        c.send_byte = byte_v;
        return c;
    endfunction

    // Offer one request and hold it until accepted. Optionally drop valid for a short
    // burst first; that drop lands in the same step as the previous acceptance, so valid
    // only ever gets one assignment per step.
    task automatic push_cmd(cmd_t c);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        n_items++;
    endtask

    // One device clock falling edge; send_byte is a don't-care here, so randomize it.
    task automatic line_edge(logic bit_v);
        push_cmd(make_cmd(ACT_EDGE, bit_v, 8'($urandom_range(0, 255))));
    endtask

    task automatic pop_req();
        push_cmd(make_cmd(ACT_POP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
    endtask

    task automatic noise_req();
        push_cmd(make_cmd(action_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255))));
    endtask

    // Device-to-host frame: start, 8 data bits LSB first, odd parity, stop.
    // Corrupt parity or stop on request to hit the error returns.
    task automatic device_frame(logic [7:0] b, bit bad_par, bit bad_stop);
        line_edge(1'b0);
        for (int i = 0; i < 8; i++)
            line_edge(b[i]);
        line_edge((~^b) ^ bad_par);
        line_edge(~bad_stop);
    endtask

    // Host-to-device transfer: send request, then edges for data, parity and stop as far as
    // the edges argument reaches (data line ignored there), then the ACK edge. Fewer edges
    // leave the transfer open so the next send request abandons it.
    task automatic host_transfer(logic [7:0] b, int edges, logic ack_bit);
        push_cmd(make_cmd(ACT_SEND, 1'($urandom_range(0, 1)), b));
        for (int i = 0; i < edges && i < 10; i++)
            line_edge(1'($urandom_range(0, 1)));
        if (edges > 10)
            line_edge(ack_bit);
    endtask

    // Watchdog: end the run if it never reaches its verdict.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int  directed_items;
        int  seq_no;
        int  pick;
        bit  fill;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pop, unused action code, bad start, a full 0xFF frame and its
        // pop, a send abandoned by a second send, then a full send with a good ACK.
        pop_req();
        push_cmd(make_cmd(ACT_UNUSED, 1'b1, 8'hFF));
        line_edge(1'b1);
        device_frame(8'hFF, 1'b0, 1'b0);
        pop_req();
        host_transfer(8'h00, 1, 1'b0);
        host_transfer(8'hA5, 11, 1'b0);
        directed_items = n_items;

        // Random: mostly well-formed frames and transfers with random content, some
        // corrupted, plus pops and noise. Alternate drain windows with fill windows that
        // withhold pops so the FIFO runs into overflow.
        seq_no = 0;
        while (n_items < directed_items + RANDOM_ITEMS) begin
            fill = (seq_no % 48) >= 20;
            if (n_items > directed_items + (RANDOM_ITEMS * 9) / 10)
                idle_allowed = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 45 || (fill && pick < 88)) begin
                device_frame(8'($urandom_range(0, 255)),
                             $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
            end else if (pick < 70) begin
                host_transfer(8'($urandom_range(0, 255)),
                              ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) : 11,
                              $urandom_range(0, 5) == 0);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 6))
                    pop_req();
            end else begin
                noise_req();
            end
            seq_no++;
        end
        cmd_valid <= 1'b0;

        // Drain: wait for every expected result, then wait out DRAIN_CYCLES to catch strays.
        // Sample on the falling edge so the checker's update at the rising edge is settled.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ps2_hse_pkg.sv
sv/ps2_host_serial_engine.sv
sv/ps2_hse_checker.sv
dv/ps2_hse_checker.sv
dv/ps2_host_serial_engine_tb.sv
